>>> src/ethernet_ipv4_l4_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Ethernet/IPv4/L4 classifier core
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IPV4_L4_CLASSIFIER_CORE_MACROS_SVH
`define ETHERNET_IPV4_L4_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication.
`define EIPC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EIPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/eipc_pkg.sv
// ----------------------------------------------------------------------------
// eipc_pkg
// Types and codes shared by the classifier core modules.
// ----------------------------------------------------------------------------
package eipc_pkg;

	localparam int OUT_CNT_BITS = 32;

	// packet classes
	localparam logic [3:0] PKT_RUNT      = 4'd0;
	localparam logic [3:0] PKT_IP_SHORT  = 4'd1;
	localparam logic [3:0] PKT_NO_PAYLD  = 4'd2;
	localparam logic [3:0] PKT_TCP       = 4'd3;
	localparam logic [3:0] PKT_UDP       = 4'd4;
	localparam logic [3:0] PKT_ICMP      = 4'd5;
	localparam logic [3:0] PKT_OTHER     = 4'd6;
	localparam logic [3:0] PKT_TCP_SHORT = 4'd7;
	localparam logic [3:0] PKT_UDP_SHORT = 4'd8;

	// application codes
	localparam logic [3:0] APP_NONE   = 4'd0;
	localparam logic [3:0] APP_HTTP   = 4'd1;
	localparam logic [3:0] APP_HTTPS  = 4'd2;
	localparam logic [3:0] APP_FTP    = 4'd3;
	localparam logic [3:0] APP_SSH    = 4'd4;
	localparam logic [3:0] APP_TELNET = 4'd5;
	localparam logic [3:0] APP_SMTP   = 4'd6;
	localparam logic [3:0] APP_DNS    = 4'd7;
	localparam logic [3:0] APP_DHCP   = 4'd8;
	localparam logic [3:0] APP_NTP    = 4'd9;
	localparam logic [3:0] APP_SNMP   = 4'd10;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       last_byte;
	} eipc_in_t;

	typedef struct packed {
		logic [3:0]              pkt_class;
		logic [3:0]              app_class;
		logic [5:0]              tcp_flag_bits;
		logic [15:0]             source_port;
		logic [15:0]             destination_port;
		logic [7:0]              ip_proto;
		logic [OUT_CNT_BITS-1:0] total_count;
		logic [OUT_CNT_BITS-1:0] tcp_count;
		logic [OUT_CNT_BITS-1:0] udp_count;
		logic [OUT_CNT_BITS-1:0] icmp_count;
		logic [OUT_CNT_BITS-1:0] other_count;
	} eipc_out_t;

	// header fields as seen after the current byte is captured
	typedef struct packed {
		logic [8:0]  frame_len;
		logic [15:0] ether_type;
		logic [7:0]  ver_ihl;
		logic [7:0]  protocol;
		logic [15:0] l4_sport;
		logic [15:0] l4_dport;
		logic [7:0]  flags;
	} eipc_hdr_t;

	typedef struct packed {
		logic [3:0]  pkt_class;
		logic [3:0]  app_class;
		logic [5:0]  tcp_flag_bits;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [7:0]  ip_proto;
	} eipc_cls_t;

	typedef struct packed {
		logic [OUT_CNT_BITS-1:0] total;
		logic [OUT_CNT_BITS-1:0] tcp;
		logic [OUT_CNT_BITS-1:0] udp;
		logic [OUT_CNT_BITS-1:0] icmp;
		logic [OUT_CNT_BITS-1:0] other;
	} eipc_counts_t;

endpackage

>>> src/eipc_stream_if.sv
// ----------------------------------------------------------------------------
// eipc_stream_if
// Valid/ready channel carrying one payload word of type T.
// ----------------------------------------------------------------------------
interface eipc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/eipc_capture.sv
// ----------------------------------------------------------------------------
// eipc_capture
// Byte offset and header capture registers for the frame in progress.
// ----------------------------------------------------------------------------
`include "ethernet_ipv4_l4_classifier_core_macros.svh"

module eipc_capture
	import eipc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output eipc_hdr_t  hdr
);

	localparam logic [7:0] OFF_TYPE_HI = 8'd12;
	localparam logic [7:0] OFF_TYPE_LO = 8'd13;
	localparam logic [7:0] OFF_VER_IHL = 8'd14;
	localparam logic [7:0] OFF_PROTO   = 8'd23;
	localparam logic [7:0] OFF_MAX     = 8'hFF;
	localparam logic [7:0] REL_SP_HI   = 8'd0;
	localparam logic [7:0] REL_SP_LO   = 8'd1;
	localparam logic [7:0] REL_DP_HI   = 8'd2;
	localparam logic [7:0] REL_DP_LO   = 8'd3;
	localparam logic [7:0] REL_FLAGS   = 8'd13;

	logic [7:0]  off_q;
	logic [15:0] et_q, sp_q, dp_q;
	logic [7:0]  vihl_q, proto_q, flg_q;

	logic [15:0] et_n, sp_n, dp_n;
	logic [7:0]  vihl_n, proto_n, flg_n;
	logic [7:0]  l4off, rel;
	logic        in_l4;

	always_comb begin
		et_n    = et_q;
		vihl_n  = vihl_q;
		proto_n = proto_q;
		sp_n    = sp_q;
		dp_n    = dp_q;
		flg_n   = flg_q;
		if (off_q == OFF_TYPE_HI) et_n[15:8] = data_byte;
		if (off_q == OFF_TYPE_LO) et_n[7:0] = data_byte;
		if (off_q == OFF_VER_IHL) vihl_n = data_byte;
		if (off_q == OFF_PROTO) proto_n = data_byte;
		// L4 start uses the IHL just captured, so IHL 0 lands on the same byte
		l4off = OFF_VER_IHL + {2'b00, vihl_n[3:0], 2'b00};
		in_l4 = (off_q >= l4off);
		rel   = off_q - l4off;
		if (in_l4) begin
			if (rel == REL_SP_HI) sp_n[15:8] = data_byte;
			if (rel == REL_SP_LO) sp_n[7:0] = data_byte;
			if (rel == REL_DP_HI) dp_n[15:8] = data_byte;
			if (rel == REL_DP_LO) dp_n[7:0] = data_byte;
			if (rel == REL_FLAGS) flg_n = data_byte;
		end
		hdr.frame_len  = {1'b0, off_q} + 9'd1;
		hdr.ether_type = et_n;
		hdr.ver_ihl    = vihl_n;
		hdr.protocol   = proto_n;
		hdr.l4_sport   = sp_n;
		hdr.l4_dport   = dp_n;
		hdr.flags      = flg_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			et_q    <= '0;
			vihl_q  <= '0;
			proto_q <= '0;
			sp_q    <= '0;
			dp_q    <= '0;
			flg_q   <= '0;
		end else if (step) begin
			if (last_byte) begin
				// frame done: drop all captures
				off_q   <= '0;
				et_q    <= '0;
				vihl_q  <= '0;
				proto_q <= '0;
				sp_q    <= '0;
				dp_q    <= '0;
				flg_q   <= '0;
			end else begin
				off_q   <= (off_q == OFF_MAX) ? off_q : off_q + 8'd1;
				et_q    <= et_n;
				vihl_q  <= vihl_n;
				proto_q <= proto_n;
				sp_q    <= sp_n;
				dp_q    <= dp_n;
				flg_q   <= flg_n;
			end
		end
	end

	`EIPC_ASSERT_NEXT(a_offset_restart, step && last_byte, off_q == '0 && et_q == '0,
		"capture state not cleared after frame end")

endmodule

>>> src/eipc_classify.sv
// ----------------------------------------------------------------------------
// eipc_classify
// Packet class, application code and reported fields from captured header.
// ----------------------------------------------------------------------------
module eipc_classify
	import eipc_pkg::*;
(
	input  eipc_hdr_t hdr,
	output eipc_cls_t res
);

	localparam logic [15:0] ETH_IPV4    = 16'h0800;
	localparam logic [8:0]  ETH_HDR_LEN = 9'd14;
	localparam logic [8:0]  IP_MIN_LEN  = 9'd20;
	localparam logic [8:0]  TCP_MIN_LEN = 9'd20;
	localparam logic [8:0]  UDP_MIN_LEN = 9'd8;
	localparam logic [3:0]  IP_VER4     = 4'd4;
	localparam logic [7:0]  PROTO_ICMP  = 8'd1;
	localparam logic [7:0]  PROTO_TCP   = 8'd6;
	localparam logic [7:0]  PROTO_UDP   = 8'd17;

	localparam logic [15:0] PORT_HTTP   = 16'd80;
	localparam logic [15:0] PORT_HTTPS  = 16'd443;
	localparam logic [15:0] PORT_FTP    = 16'd21;
	localparam logic [15:0] PORT_SSH    = 16'd22;
	localparam logic [15:0] PORT_TELNET = 16'd23;
	localparam logic [15:0] PORT_SMTP   = 16'd25;
	localparam logic [15:0] PORT_DNS    = 16'd53;
	localparam logic [15:0] PORT_DHCP_S = 16'd67;
	localparam logic [15:0] PORT_DHCP_C = 16'd68;
	localparam logic [15:0] PORT_NTP    = 16'd123;
	localparam logic [15:0] PORT_SNMP   = 16'd161;
	localparam logic [15:0] PORT_TRAP   = 16'd162;

	function automatic logic hit(input logic [15:0] s, input logic [15:0] d,
			input logic [15:0] p);
		return (s == p) || (d == p);
	endfunction

	function automatic logic [3:0] tcp_app(input logic [15:0] s, input logic [15:0] d);
		logic [3:0] app;
		priority if (hit(s, d, PORT_HTTP))   app = APP_HTTP;
		else if (hit(s, d, PORT_HTTPS))      app = APP_HTTPS;
		else if (hit(s, d, PORT_FTP))        app = APP_FTP;
		else if (hit(s, d, PORT_SSH))        app = APP_SSH;
		else if (hit(s, d, PORT_TELNET))     app = APP_TELNET;
		else if (hit(s, d, PORT_SMTP))       app = APP_SMTP;
		else if (hit(s, d, PORT_DNS))        app = APP_DNS;
		else                                 app = APP_NONE;
		return app;
	endfunction

	function automatic logic [3:0] udp_app(input logic [15:0] s, input logic [15:0] d);
		logic [3:0] app;
		priority if (hit(s, d, PORT_DNS)) app = APP_DNS;
		else if (hit(s, d, PORT_DHCP_S) || hit(s, d, PORT_DHCP_C)) app = APP_DHCP;
		else if (hit(s, d, PORT_NTP)) app = APP_NTP;
		else if (hit(s, d, PORT_SNMP) || hit(s, d, PORT_TRAP)) app = APP_SNMP;
		else app = APP_NONE;
		return app;
	endfunction

	logic [8:0] hl, l4_start;

	always_comb begin
		hl       = {3'b000, hdr.ver_ihl[3:0], 2'b00};
		l4_start = ETH_HDR_LEN + hl;
		res      = '0;
		priority if (hdr.frame_len < ETH_HDR_LEN) begin
			res.pkt_class = PKT_RUNT;
		end else if (hdr.ether_type != ETH_IPV4) begin
			res.pkt_class = PKT_OTHER;
		end else if (hdr.frame_len < ETH_HDR_LEN + IP_MIN_LEN) begin
			res.pkt_class = PKT_IP_SHORT;
		end else if (hdr.ver_ihl[7:4] != IP_VER4) begin
			res.pkt_class = PKT_OTHER;
		end else begin
			res.ip_proto = hdr.protocol;
			priority if (hdr.frame_len <= l4_start) begin
				res.pkt_class = PKT_NO_PAYLD;
			end else if (hdr.protocol == PROTO_TCP) begin
				if (hdr.frame_len < l4_start + TCP_MIN_LEN) begin
					res.pkt_class = PKT_TCP_SHORT;
				end else begin
					res.pkt_class        = PKT_TCP;
					res.source_port      = hdr.l4_sport;
					res.destination_port = hdr.l4_dport;
					res.tcp_flag_bits    = hdr.flags[5:0];
					res.app_class        = tcp_app(hdr.l4_sport, hdr.l4_dport);
				end
			end else if (hdr.protocol == PROTO_UDP) begin
				if (hdr.frame_len < l4_start + UDP_MIN_LEN) begin
					res.pkt_class = PKT_UDP_SHORT;
				end else begin
					res.pkt_class        = PKT_UDP;
					res.source_port      = hdr.l4_sport;
					res.destination_port = hdr.l4_dport;
					res.app_class        = udp_app(hdr.l4_sport, hdr.l4_dport);
				end
			end else if (hdr.protocol == PROTO_ICMP) begin
				res.pkt_class = PKT_ICMP;
			end else begin
				res.pkt_class = PKT_OTHER;
			end
		end
	end

endmodule

>>> src/eipc_counters.sv
// ----------------------------------------------------------------------------
// eipc_counters
// Five wrapping frame counters: total, tcp, udp, icmp, other.
// ----------------------------------------------------------------------------
`include "ethernet_ipv4_l4_classifier_core_macros.svh"

module eipc_counters
	import eipc_pkg::*;
#(
	parameter int COUNTER_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         clr,
	input  logic         bump,
	input  logic [3:0]   pkt_class,
	output eipc_counts_t counts
);

	localparam int CNT_NUM   = 5;
	localparam int CNT_TOTAL = 0;
	localparam int CNT_TCP   = 1;
	localparam int CNT_UDP   = 2;
	localparam int CNT_ICMP  = 3;
	localparam int CNT_OTHER = 4;

	logic [COUNTER_BITS-1:0] cnt_q [CNT_NUM];
	logic [COUNTER_BITS-1:0] cnt_n [CNT_NUM];
	logic [OUT_CNT_BITS-1:0] cnt_out [CNT_NUM];
	logic [CNT_NUM-1:0]      inc;

	always_comb begin
		inc            = '0;
		inc[CNT_TOTAL] = bump;
		inc[CNT_TCP]   = bump && (pkt_class == PKT_TCP);
		inc[CNT_UDP]   = bump && (pkt_class == PKT_UDP);
		inc[CNT_ICMP]  = bump && (pkt_class == PKT_ICMP);
		inc[CNT_OTHER] = bump && (pkt_class == PKT_OTHER);
	end

	for (genvar i = 0; i < CNT_NUM; i++) begin : g_cnt
		assign cnt_n[i] = cnt_q[i] + COUNTER_BITS'(inc[i]);

		if (COUNTER_BITS >= OUT_CNT_BITS) begin : g_trunc
			assign cnt_out[i] = cnt_n[i][OUT_CNT_BITS-1:0];
		end else begin : g_ext
			assign cnt_out[i] = {{(OUT_CNT_BITS-COUNTER_BITS){1'b0}}, cnt_n[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (clr) begin
				cnt_q[i] <= '0;
			end else if (bump) begin
				cnt_q[i] <= cnt_n[i];
			end
		end
	end

	assign counts.total = cnt_out[CNT_TOTAL];
	assign counts.tcp   = cnt_out[CNT_TCP];
	assign counts.udp   = cnt_out[CNT_UDP];
	assign counts.icmp  = cnt_out[CNT_ICMP];
	assign counts.other = cnt_out[CNT_OTHER];

	`EIPC_ASSERT_NEXT(a_clear_zeroes, clr,
		cnt_q[CNT_TOTAL] == '0 && cnt_q[CNT_TCP] == '0 && cnt_q[CNT_OTHER] == '0,
		"counters not zero after clear")

endmodule

>>> src/ethernet_ipv4_l4_classifier_core.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_l4_classifier_core
// Byte-stream Ethernet/IPv4/TCP/UDP header classifier with frame counters.
// ----------------------------------------------------------------------------
// Usage:
//   ingress carries one word per handshake: a frame byte with its last-byte
//   mark, or a counter clear request (req_type = 1). Frame bytes arrive in
//   wire order; words are taken back to back except as Stall describes.
//   egress carries one result word per frame, issued for the word that holds
//   the last byte: packet class, application code, TCP flags, ports, IP
//   protocol and the five counters after this frame's update.
//   Result path: the last byte is held in the input register, then its
//   result in the result register. Throughput: one word per cycle unless a
//   last byte stalls, set by the single capture/classify pass between them.
//   Stall: while a result waits on egress, ingress keeps accepting bytes
//   until the next last byte reaches the input register; it then holds
//   there until the waiting result is taken.
//   Reset: counters, captures and offset clear at once; no clearing pass.
//   A clear request zeroes the counters, gives no result and leaves the
//   frame in progress untouched.
// ----------------------------------------------------------------------------
`include "ethernet_ipv4_l4_classifier_core_macros.svh"

module ethernet_ipv4_l4_classifier_core
	import eipc_pkg::*;
#(
	parameter int COUNTER_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	eipc_stream_if.sink   ingress,
	eipc_stream_if.source egress
);

	eipc_in_t     word_s1;
	logic         valid_s1;
	eipc_out_t    res_q;
	logic         res_valid_q;

	logic         res_free, adv_s1, res_load, step, clr;
	eipc_hdr_t    hdr;
	eipc_cls_t    cls;
	eipc_counts_t counts;

	assign res_free = !res_valid_q || egress.ready;
	// a frame byte without last mark or a clear never waits on egress
	assign adv_s1   = valid_s1 && (word_s1.req_type || !word_s1.last_byte || res_free);
	assign step     = adv_s1 && !word_s1.req_type;
	assign clr      = adv_s1 && word_s1.req_type;
	assign res_load = step && word_s1.last_byte;

	assign ingress.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ingress.valid && ingress.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ingress.valid && ingress.ready) begin
			word_s1 <= ingress.data;
		end
	end

	eipc_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (word_s1.data_byte),
		.last_byte (word_s1.last_byte),
		.hdr       (hdr)
	);

	eipc_classify u_classify (
		.hdr (hdr),
		.res (cls)
	);

	eipc_counters #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_counters (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (clr),
		.bump      (res_load),
		.pkt_class (cls.pkt_class),
		.counts    (counts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (egress.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.pkt_class        <= cls.pkt_class;
			res_q.app_class        <= cls.app_class;
			res_q.tcp_flag_bits    <= cls.tcp_flag_bits;
			res_q.source_port      <= cls.source_port;
			res_q.destination_port <= cls.destination_port;
			res_q.ip_proto         <= cls.ip_proto;
			res_q.total_count      <= counts.total;
			res_q.tcp_count        <= counts.tcp;
			res_q.udp_count        <= counts.udp;
			res_q.icmp_count       <= counts.icmp;
			res_q.other_count      <= counts.other;
		end
	end

	assign egress.valid = res_valid_q;
	assign egress.data  = res_q;

	`EIPC_ASSERT_NEXT(a_accept_fills_s1, ingress.valid && ingress.ready, valid_s1,
		"accepted word did not reach the input register")
	`EIPC_ASSERT_IMPL(a_last_byte_waits,
		valid_s1 && !word_s1.req_type && word_s1.last_byte && res_valid_q && !egress.ready,
		!ingress.ready && !res_load,
		"last byte advanced over a waiting result")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Ethernet/IPv4/L4 classifier core. A driver
// process streams frame bytes and counter clears from a queue of pending
// words. A classifier model predicts each per-frame result, and a monitor
// compares every egress word, field by field, against the oldest prediction.
// Sender gaps and receiver stalls vary by phase. One long receiver hold-off
// fills the core. Between phases the sender drains until no result is
// outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
	import eipc_pkg::*;
();

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_WORDS  = 280;
	localparam int SETTLE_CYCLES = 10;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [15:0] PORT_FTP     = 16'd21;
	localparam logic [15:0] PORT_SSH     = 16'd22;
	localparam logic [15:0] PORT_TELNET  = 16'd23;
	localparam logic [15:0] PORT_SMTP    = 16'd25;
	localparam logic [15:0] PORT_DNS     = 16'd53;
	localparam logic [15:0] PORT_DHCP_S  = 16'd67;
	localparam logic [15:0] PORT_DHCP_C  = 16'd68;
	localparam logic [15:0] PORT_HTTP    = 16'd80;
	localparam logic [15:0] PORT_NTP     = 16'd123;
	localparam logic [15:0] PORT_SNMP    = 16'd161;
	localparam logic [15:0] PORT_SNMP_TR = 16'd162;
	localparam logic [15:0] PORT_HTTPS   = 16'd443;

	localparam int NO_CLEAR = -1;

	typedef enum int {
		PH_NO_IDLE,
		PH_TX_IDLE,
		PH_RX_STALL,
		PH_BOTH_IDLE
	} idle_phase_e;

	logic clk = 1'b0;
	logic arst_n;

	eipc_stream_if #(.T(eipc_in_t))  ingress_ch ();
	eipc_stream_if #(.T(eipc_out_t)) egress_ch ();

	ethernet_ipv4_l4_classifier_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.ingress(ingress_ch.sink),
		.egress (egress_ch.source)
	);

	// frame capture state of the model
	logic [7:0]   frm_off;
	logic [15:0]  frm_etype;
	logic [7:0]   frm_vihl;
	logic [7:0]   frm_proto;
	logic [15:0]  frm_sport;
	logic [15:0]  frm_dport;
	logic [7:0]   frm_flags;
	eipc_counts_t frame_counts;

	eipc_in_t    pending_words[$];
	eipc_out_t   expected_results[$];
	idle_phase_e idle_phase = PH_NO_IDLE;

	bit word_taken;
	int rx_hold_left;
	int cycle_cnt;
	int mismatches;
	int results_checked;
	int words_accepted;
	int words_queued;
	int frames_queued;
	int clears_queued;
	int class_hits[16];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [3:0] tcp_app_code(input logic [15:0] s, input logic [15:0] d);
		if (s == PORT_HTTP || d == PORT_HTTP)     return APP_HTTP;
		if (s == PORT_HTTPS || d == PORT_HTTPS)   return APP_HTTPS;
		if (s == PORT_FTP || d == PORT_FTP)       return APP_FTP;
		if (s == PORT_SSH || d == PORT_SSH)       return APP_SSH;
		if (s == PORT_TELNET || d == PORT_TELNET) return APP_TELNET;
		if (s == PORT_SMTP || d == PORT_SMTP)     return APP_SMTP;
		if (s == PORT_DNS || d == PORT_DNS)       return APP_DNS;
		return APP_NONE;
	endfunction

	function automatic logic [3:0] udp_app_code(input logic [15:0] s, input logic [15:0] d);
		if (s == PORT_DNS || d == PORT_DNS) return APP_DNS;
		if (s == PORT_DHCP_S || d == PORT_DHCP_S || s == PORT_DHCP_C || d == PORT_DHCP_C)
			return APP_DHCP;
		if (s == PORT_NTP || d == PORT_NTP) return APP_NTP;
		if (s == PORT_SNMP || d == PORT_SNMP || s == PORT_SNMP_TR || d == PORT_SNMP_TR)
			return APP_SNMP;
		return APP_NONE;
	endfunction

	task automatic clear_capture();
		frm_off   = '0;
		frm_etype = '0;
		frm_vihl  = '0;
		frm_proto = '0;
		frm_sport = '0;
		frm_dport = '0;
		frm_flags = '0;
	endtask

	// Advance the classifier model by one accepted word.
	task automatic classify_word(input eipc_in_t w);
		int off;
		int l4off;
		int rel;
		int len;
		int iplen;
		int hl;
		int rem;
		eipc_out_t r;
		if (w.req_type) begin
			frame_counts = '0;
			return;
		end
		off = int'(frm_off);
		if (off == 12) frm_etype[15:8] = w.data_byte;
		if (off == 13) frm_etype[7:0] = w.data_byte;
		if (off == 14) frm_vihl = w.data_byte;
		if (off == 23) frm_proto = w.data_byte;
		if (off >= 14) begin
			// L4 offset follows the IHL just captured, even when it overlaps the IP header
			l4off = 14 + int'(frm_vihl[3:0]) * 4;
			if (off >= l4off) begin
				rel = off - l4off;
				case (rel)
					0: frm_sport[15:8] = w.data_byte;
					1: frm_sport[7:0] = w.data_byte;
					2: frm_dport[15:8] = w.data_byte;
					3: frm_dport[7:0] = w.data_byte;
					13: frm_flags = w.data_byte;
					default: ;
				endcase
			end
		end
		if (frm_off != 8'd255) frm_off = frm_off + 8'd1;
		if (!w.last_byte) return;

		len = off + 1;
		r = '0;
		frame_counts.total = frame_counts.total + 32'd1;
		if (len < 14) begin
			r.pkt_class = PKT_RUNT;
		end else if (frm_etype != ETYPE_IPV4) begin
			r.pkt_class = PKT_OTHER;
			frame_counts.other = frame_counts.other + 32'd1;
		end else if (len - 14 < 20) begin
			r.pkt_class = PKT_IP_SHORT;
		end else if (frm_vihl[7:4] != 4'd4) begin
			r.pkt_class = PKT_OTHER;
			frame_counts.other = frame_counts.other + 32'd1;
		end else begin
			r.ip_proto = frm_proto;
			iplen = len - 14;
			hl = int'(frm_vihl[3:0]) * 4;
			rem = iplen - hl;
			if (iplen <= hl) begin
				r.pkt_class = PKT_NO_PAYLD;
			end else if (frm_proto == PROTO_TCP) begin
				if (rem < 20) begin
					r.pkt_class = PKT_TCP_SHORT;
				end else begin
					r.pkt_class = PKT_TCP;
					frame_counts.tcp = frame_counts.tcp + 32'd1;
					r.source_port = frm_sport;
					r.destination_port = frm_dport;
					r.tcp_flag_bits = frm_flags[5:0];
					r.app_class = tcp_app_code(frm_sport, frm_dport);
				end
			end else if (frm_proto == PROTO_UDP) begin
				if (rem < 8) begin
					r.pkt_class = PKT_UDP_SHORT;
				end else begin
					r.pkt_class = PKT_UDP;
					frame_counts.udp = frame_counts.udp + 32'd1;
					r.source_port = frm_sport;
					r.destination_port = frm_dport;
					r.app_class = udp_app_code(frm_sport, frm_dport);
				end
			end else if (frm_proto == PROTO_ICMP) begin
				r.pkt_class = PKT_ICMP;
				frame_counts.icmp = frame_counts.icmp + 32'd1;
			end else begin
				r.pkt_class = PKT_OTHER;
				frame_counts.other = frame_counts.other + 32'd1;
			end
		end
		r.total_count = frame_counts.total;
		r.tcp_count   = frame_counts.tcp;
		r.udp_count   = frame_counts.udp;
		r.icmp_count  = frame_counts.icmp;
		r.other_count = frame_counts.other;
		expected_results.push_back(r);
		class_hits[r.pkt_class]++;
		clear_capture();
	endtask

	task automatic queue_clear();
		eipc_in_t w;
		w.req_type  = 1'b1;
		w.data_byte = 8'($urandom_range(255));
		w.last_byte = 1'($urandom_range(1));
		pending_words.push_back(w);
		words_queued++;
		clears_queued++;
	endtask

	// Build one frame of random filler with the given header fields laid over it.
	// A clear is inserted before byte clear_at unless it is NO_CLEAR.
	task automatic queue_frame(input int len, input logic [15:0] etype, input logic [7:0] vihl,
			input logic [7:0] proto, input logic [15:0] sport, input logic [15:0] dport,
			input logic [7:0] flags, input int clear_at);
		logic [7:0] fb[$];
		int l4;
		eipc_in_t w;
		for (int i = 0; i < len; i++) fb.push_back(8'($urandom_range(255)));
		l4 = 14 + int'(vihl[3:0]) * 4;
		// L4 fields first, so the IP header bytes win where they overlap
		if (l4 < len)      fb[l4] = sport[15:8];
		if (l4 + 1 < len)  fb[l4 + 1] = sport[7:0];
		if (l4 + 2 < len)  fb[l4 + 2] = dport[15:8];
		if (l4 + 3 < len)  fb[l4 + 3] = dport[7:0];
		if (l4 + 13 < len) fb[l4 + 13] = flags;
		if (12 < len) fb[12] = etype[15:8];
		if (13 < len) fb[13] = etype[7:0];
		if (14 < len) fb[14] = vihl;
		if (23 < len) fb[23] = proto;
		for (int i = 0; i < len; i++) begin
			if (i == clear_at) queue_clear();
			w.req_type  = 1'b0;
			w.data_byte = fb[i];
			w.last_byte = (i == len - 1);
			pending_words.push_back(w);
			words_queued++;
		end
		frames_queued++;
	endtask

	function automatic logic [15:0] pick_port();
		case ($urandom_range(15))
			0: return PORT_HTTP;
			1: return PORT_HTTPS;
			2: return PORT_FTP;
			3: return PORT_SSH;
			4: return PORT_TELNET;
			5: return PORT_SMTP;
			6: return PORT_DNS;
			7: return PORT_DHCP_S;
			8: return PORT_DHCP_C;
			9: return PORT_NTP;
			10: return PORT_SNMP;
			11: return PORT_SNMP_TR;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic queue_random_frame();
		int ihl;
		int l4len;
		int len;
		int clear_at;
		logic [15:0] etype;
		logic [7:0] vihl;
		logic [7:0] proto;
		if ($urandom_range(99) < 72) begin
			// IPv4 with version 4, mostly IHL 5, and random content
			etype = ETYPE_IPV4;
			ihl = ($urandom_range(9) == 0) ? $urandom_range(15) : 5;
			vihl = {4'd4, 4'(ihl)};
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					proto = PROTO_TCP;
					l4len = ($urandom_range(4) == 0) ? $urandom_range(19) : $urandom_range(20, 40);
				end
				4, 5, 6: begin
					proto = PROTO_UDP;
					l4len = ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(8, 30);
				end
				7: begin
					proto = PROTO_ICMP;
					l4len = $urandom_range(20);
				end
				default: begin
					proto = 8'($urandom_range(255));
					l4len = $urandom_range(20);
				end
			endcase
			len = 14 + ihl * 4 + l4len;
		end else begin
			case ($urandom_range(5))
				0: etype = ETYPE_ARP;
				1: etype = ETYPE_IPV6;
				2: etype = ETYPE_IPV4;
				3: etype = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
				default: etype = 16'($urandom_range(65535));
			endcase
			vihl = 8'($urandom_range(255));
			proto = 8'($urandom_range(255));
			len = $urandom_range(1, 70);
		end
		if ($urandom_range(59) == 0) len = $urandom_range(240, 300);
		clear_at = ($urandom_range(29) == 0) ? $urandom_range(len - 1) : NO_CLEAR;
		queue_frame(len, etype, vihl, proto, pick_port(), pick_port(),
			8'($urandom_range(255)), clear_at);
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || ingress_ch.valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at result %0d: expected %0h, got %0h",
				what, results_checked, want, got);
	endtask

	task automatic check_result(input eipc_out_t want, input eipc_out_t got);
		if (got.pkt_class !== want.pkt_class)
			note_mismatch("pkt_class", 32'(want.pkt_class), 32'(got.pkt_class));
		if (got.app_class !== want.app_class)
			note_mismatch("app_class", 32'(want.app_class), 32'(got.app_class));
		if (got.tcp_flag_bits !== want.tcp_flag_bits)
			note_mismatch("tcp_flag_bits", 32'(want.tcp_flag_bits), 32'(got.tcp_flag_bits));
		if (got.source_port !== want.source_port)
			note_mismatch("source_port", 32'(want.source_port), 32'(got.source_port));
		if (got.destination_port !== want.destination_port)
			note_mismatch("destination_port", 32'(want.destination_port),
				32'(got.destination_port));
		if (got.ip_proto !== want.ip_proto)
			note_mismatch("ip_proto", 32'(want.ip_proto), 32'(got.ip_proto));
		if (got.total_count !== want.total_count)
			note_mismatch("total_count", want.total_count, got.total_count);
		if (got.tcp_count !== want.tcp_count)
			note_mismatch("tcp_count", want.tcp_count, got.tcp_count);
		if (got.udp_count !== want.udp_count)
			note_mismatch("udp_count", want.udp_count, got.udp_count);
		if (got.icmp_count !== want.icmp_count)
			note_mismatch("icmp_count", want.icmp_count, got.icmp_count);
		if (got.other_count !== want.other_count)
			note_mismatch("other_count", want.other_count, got.other_count);
	endtask

	// ingress acceptance: feed the model
	always @(posedge clk) begin
		if (arst_n && ingress_ch.valid && ingress_ch.ready) begin
			classify_word(ingress_ch.data);
			word_taken = 1'b1;
			words_accepted++;
		end
	end

	// driver: hold the word until taken, then offer the next or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			ingress_ch.valid <= 1'b0;
		end else if (!ingress_ch.valid || word_taken) begin
			word_taken = 1'b0;
			if (pending_words.size() != 0 &&
					!((idle_phase == PH_TX_IDLE && $urandom_range(99) < 69) ||
					(idle_phase == PH_BOTH_IDLE && $urandom_range(99) < 6))) begin
				ingress_ch.data <= pending_words.pop_front();
				ingress_ch.valid <= 1'b1;
			end else begin
				ingress_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: long hold-off when requested, else phase-dependent stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			egress_ch.ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			egress_ch.ready <= 1'b0;
			rx_hold_left--;
		end else begin
			egress_ch.ready <= !((idle_phase == PH_RX_STALL && $urandom_range(99) < 69) ||
				(idle_phase == PH_BOTH_IDLE && $urandom_range(99) < 6));
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && egress_ch.valid && egress_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: class %0d total %0d",
						egress_ch.data.pkt_class, egress_ch.data.total_count);
			end else begin
				check_result(expected_results.pop_front(), egress_ch.data);
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, expected_results.size());
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		int chunk;
		int target;
		arst_n = 1'b0;
		ingress_ch.valid = 1'b0;
		ingress_ch.data = '0;
		egress_ch.ready = 1'b0;
		frame_counts = '0;
		clear_capture();
		// back-pressure the core hard while the sender starts the directed frames
		rx_hold_left = 400;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames
		queue_frame(1, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, NO_CLEAR);
		queue_frame(13, ETYPE_IPV4, 8'h45, PROTO_TCP, 16'd1, 16'd2, 8'h00, NO_CLEAR);
		queue_frame(14, ETYPE_ARP, 8'h45, PROTO_TCP, 16'd1, 16'd2, 8'h00, NO_CLEAR);
		queue_frame(60, ETYPE_IPV6, 8'h60, PROTO_TCP, 16'd1, 16'd2, 8'h00, NO_CLEAR);
		queue_frame(33, ETYPE_IPV4, 8'h45, PROTO_TCP, 16'd1, 16'd2, 8'h00, NO_CLEAR);
		queue_frame(34, ETYPE_IPV4, 8'h45, PROTO_TCP, 16'd1, 16'd2, 8'h00, NO_CLEAR);
		queue_frame(54, ETYPE_IPV4, 8'h65, PROTO_TCP, 16'd1, 16'd2, 8'h00, NO_CLEAR);
		queue_frame(53, ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_HTTP, 16'd1234, 8'hFF, NO_CLEAR);
		queue_frame(54, ETYPE_IPV4, 8'h45, PROTO_TCP, 16'd1234, PORT_HTTP, 8'hFF, NO_CLEAR);
		queue_frame(60, ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_HTTPS, 16'hFFFF, 8'hC0, NO_CLEAR);
		queue_frame(41, ETYPE_IPV4, 8'h45, PROTO_UDP, PORT_DNS, 16'd0, 8'h00, NO_CLEAR);
		queue_frame(42, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd0, PORT_DNS, 8'h00, NO_CLEAR);
		queue_frame(42, ETYPE_IPV4, 8'h45, PROTO_UDP, PORT_DHCP_C, PORT_SNMP_TR, 8'h00,
			NO_CLEAR);
		queue_frame(40, ETYPE_IPV4, 8'h45, PROTO_ICMP, 16'd0, 16'd0, 8'h00, NO_CLEAR);
		queue_frame(40, ETYPE_IPV4, 8'h45, 8'hFF, 16'd0, 16'd0, 8'h00, NO_CLEAR);
		// IHL zero: the L4 header starts on the version/IHL byte
		queue_frame(40, ETYPE_IPV4, 8'h40, PROTO_TCP, 16'd7, PORT_SSH, 8'h3F, NO_CLEAR);
		queue_frame(40, ETYPE_IPV4, 8'h42, PROTO_UDP, PORT_NTP, 16'd9, 8'h00, NO_CLEAR);
		queue_frame(94, ETYPE_IPV4, 8'h4F, PROTO_TCP, PORT_SMTP, PORT_FTP, 8'h12, NO_CLEAR);
		// clear arrives mid-frame and must not disturb the capture
		queue_frame(54, ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_TELNET, 16'd5, 8'h01, 20);
		// offset saturation
		queue_frame(260, ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_SSH, PORT_TELNET, 8'h2A, NO_CLEAR);
		queue_frame(255, ETYPE_IPV4, 8'h45, PROTO_UDP, PORT_NTP, PORT_SNMP, 8'h00, NO_CLEAR);
		queue_clear();
		queue_frame(40, ETYPE_IPV4, 8'h45, PROTO_ICMP, 16'd0, 16'd0, 8'h00, NO_CLEAR);
		wait_drained();

		// random frames, phase by phase, draining between phases
		target = words_queued;
		for (chunk = 0; chunk < 8; chunk++) begin
			idle_phase = idle_phase_e'(chunk % 4);
			target = target + RANDOM_WORDS / 8;
			while (words_queued < target) begin
				if ($urandom_range(24) == 0) queue_clear();
				queue_random_frame();
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			mismatches += expected_results.size();
			$display("%0d results never arrived", expected_results.size());
		end
		$display("run covered %0d frames and %0d clears in %0d words, %0d results checked",
			frames_queued, clears_queued, words_accepted, results_checked);
		$display("class mix: runt %0d, ip short %0d, no payload %0d, tcp %0d, udp %0d, icmp %0d",
			class_hits[PKT_RUNT], class_hits[PKT_IP_SHORT], class_hits[PKT_NO_PAYLD],
			class_hits[PKT_TCP], class_hits[PKT_UDP], class_hits[PKT_ICMP]);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb failed");
		end
		$finish;
	end

endmodule
